FILE: rtl/tzp_pkg.sv
// ----------------------------------------------------------------------------
// tzp_pkg
// Types, codes and the per-transition parse step shared by the TZ string
// parser.
// ----------------------------------------------------------------------------
package tzp_pkg;

	localparam int unsigned MAX_HOURS_DEF  = 167;
	localparam int unsigned MAX_LENGTH_DEF = 255;
	localparam int unsigned CHAIN_STEPS    = 4;
	localparam int unsigned FIFO_DEPTH     = 8;

	localparam logic [4:0] PH_STD_FIRST      = 5'd0;
	localparam logic [4:0] PH_STD_BR         = 5'd1;
	localparam logic [4:0] PH_STD_PLAIN      = 5'd2;
	localparam logic [4:0] PH_AFTER_STD      = 5'd3;
	localparam logic [4:0] PH_DST_FIRST      = 5'd4;
	localparam logic [4:0] PH_DST_BR         = 5'd5;
	localparam logic [4:0] PH_DST_PLAIN      = 5'd6;
	localparam logic [4:0] PH_AFTER_DST_ABBR = 5'd7;
	localparam logic [4:0] PH_OFF_SIGN       = 5'd8;
	localparam logic [4:0] PH_OFF_H          = 5'd9;
	localparam logic [4:0] PH_OFF_M          = 5'd10;
	localparam logic [4:0] PH_OFF_S          = 5'd11;
	localparam logic [4:0] PH_COMMA_START    = 5'd12;
	localparam logic [4:0] PH_RULE_FIRST     = 5'd13;
	localparam logic [4:0] PH_RULE_J         = 5'd14;
	localparam logic [4:0] PH_RULE_ORD       = 5'd15;
	localparam logic [4:0] PH_RULE_MON       = 5'd16;
	localparam logic [4:0] PH_RULE_WEEK      = 5'd17;
	localparam logic [4:0] PH_RULE_WDAY      = 5'd18;
	localparam logic [4:0] PH_RULE_SLASH     = 5'd19;
	localparam logic [4:0] PH_COMMA_END      = 5'd20;
	localparam logic [4:0] PH_END            = 5'd21;

	localparam logic [2:0] K_STD_CHAR   = 3'd0;
	localparam logic [2:0] K_DST_CHAR   = 3'd1;
	localparam logic [2:0] K_STD_OFF    = 3'd2;
	localparam logic [2:0] K_DST_OFF    = 3'd3;
	localparam logic [2:0] K_START_RULE = 3'd4;
	localparam logic [2:0] K_END_RULE   = 3'd5;
	localparam logic [2:0] K_DONE       = 3'd6;
	localparam logic [2:0] K_ERROR      = 3'd7;

	localparam logic [4:0] E_NONE        = 5'd0;
	localparam logic [4:0] E_UNCLOSED    = 5'd1;
	localparam logic [4:0] E_EXP_ABBR    = 5'd2;
	localparam logic [4:0] E_EXP_INT     = 5'd3;
	localparam logic [4:0] E_BAD_MINS    = 5'd4;
	localparam logic [4:0] E_BAD_SECS    = 5'd5;
	localparam logic [4:0] E_BAD_JULIAN  = 5'd6;
	localparam logic [4:0] E_BAD_MONTH   = 5'd7;
	localparam logic [4:0] E_DOT_MONTH   = 5'd8;
	localparam logic [4:0] E_BAD_WEEK    = 5'd9;
	localparam logic [4:0] E_DOT_WEEK    = 5'd10;
	localparam logic [4:0] E_BAD_WDAY    = 5'd11;
	localparam logic [4:0] E_BAD_ORDINAL = 5'd12;
	localparam logic [4:0] E_COMMA_START = 5'd13;
	localparam logic [4:0] E_COMMA_END   = 5'd14;
	localparam logic [4:0] E_TRAILING    = 5'd15;
	localparam logic [4:0] E_TOO_LARGE   = 5'd16;

	localparam logic [1:0] RT_JULIAN  = 2'd0;
	localparam logic [1:0] RT_MWD     = 2'd1;
	localparam logic [1:0] RT_ORDINAL = 2'd2;

	localparam logic [1:0] OWN_STD   = 2'd0;
	localparam logic [1:0] OWN_DST   = 2'd1;
	localparam logic [1:0] OWN_START = 2'd2;
	localparam logic [1:0] OWN_END   = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_J     = 8'h4A;
	localparam logic [7:0] CH_M     = 8'h4D;

	localparam logic signed [20:0] SECS_HOUR     = 21'sd3600;
	localparam logic signed [20:0] DEF_RULE_TIME = 21'sd7200;
	localparam logic [8:0]         ACC_SAT       = 9'd511;
	localparam logic [8:0]         MAX_ORDINAL   = 9'd365;
	localparam logic [8:0]         MAX_MONTH     = 9'd12;
	localparam logic [8:0]         MAX_WEEK      = 9'd5;
	localparam logic [8:0]         MAX_WDAY      = 9'd6;
	localparam logic [8:0]         SIXTY         = 9'd60;

	typedef struct packed {
		logic [4:0]         phase;
		logic [8:0]         acc;
		logic               seen;
		logic               neg;
		logic [7:0]         hours;
		logic [5:0]         mins;
		logic [1:0]         rtype;
		logic [3:0]         rmon;
		logic [2:0]         rweek;
		logic [8:0]         rday;
		logic signed [20:0] std_off;
		logic [1:0]         owner;
	} parse_st_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         ch;
		logic signed [20:0] off;
		logic [1:0]         rtype;
		logic [3:0]         rmon;
		logic [2:0]         rweek;
		logic [8:0]         rday;
		logic [4:0]         ecode;
		logic [7:0]         epos;
	} result_t;

	typedef struct packed {
		parse_st_t  st;
		logic       again;
		logic       emit;
		result_t    res;
		logic [4:0] ecode;
		logic       fin;
	} step_t;

	localparam parse_st_t ST_RESET = '0;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_0) && (b <= CH_9);
	endfunction

	function automatic logic ends_plain(input logic [7:0] b);
		return (b == CH_NUL) || (b == CH_COMMA) || (b == CH_MINUS) || (b == CH_PLUS) ||
			is_digit(b);
	endfunction

	function automatic result_t make_res(input logic [2:0] kind, input logic [7:0] ch,
			input logic signed [20:0] off, input parse_st_t st);
		result_t r;
		logic    rule;
		rule    = (kind == K_START_RULE) || (kind == K_END_RULE);
		r.kind  = kind;
		r.ch    = ch;
		r.off   = off;
		r.rtype = rule ? st.rtype : 2'd0;
		r.rmon  = rule ? st.rmon : 4'd0;
		r.rweek = rule ? st.rweek : 3'd0;
		r.rday  = rule ? st.rday : 9'd0;
		r.ecode = E_NONE;
		r.epos  = 8'd0;
		return r;
	endfunction

	function automatic parse_st_t begin_int(input parse_st_t st, input logic [4:0] phase);
		parse_st_t r;
		r       = st;
		r.phase = phase;
		r.acc   = 9'd0;
		r.seen  = 1'b0;
		return r;
	endfunction

	function automatic parse_st_t begin_offset(input parse_st_t st, input logic [1:0] who);
		parse_st_t r;
		r       = st;
		r.owner = who;
		r.neg   = 1'b0;
		r.hours = 8'd0;
		r.mins  = 6'd0;
		r.phase = PH_OFF_SIGN;
		return r;
	endfunction

	function automatic step_t rule_done(input step_t s, input logic signed [20:0] tod);
		step_t r;
		r      = s;
		r.emit = 1'b1;
		if (s.st.owner == OWN_END) begin
			r.res      = make_res(K_END_RULE, CH_NUL, tod, s.st);
			r.st.phase = PH_END;
		end else begin
			r.res      = make_res(K_START_RULE, CH_NUL, tod, s.st);
			r.st.phase = PH_COMMA_END;
		end
		return r;
	endfunction

	function automatic step_t finish_offset(input step_t s, input logic signed [20:0] val);
		step_t r;
		r      = s;
		r.emit = 1'b1;
		case (s.st.owner)
			OWN_STD: begin
				r.st.std_off = -val;
				r.res        = make_res(K_STD_OFF, CH_NUL, -val, s.st);
				r.st.phase   = PH_AFTER_STD;
			end
			OWN_DST: begin
				r.res      = make_res(K_DST_OFF, CH_NUL, -val, s.st);
				r.st.phase = PH_COMMA_START;
			end
			default: begin
				r = rule_done(s, val);
			end
		endcase
		return r;
	endfunction

	// One state transition. The offset magnitude is formed outside from the
	// registered state, since an offset can only complete on the first
	// transition of a byte.
	function automatic step_t tz_step(input parse_st_t st, input logic [7:0] b,
			input logic [7:0] max_hours, input logic [19:0] mag);
		step_t              s;
		logic               dig_ok;
		logic [12:0]        acc_w;
		logic [8:0]         acc_n;
		logic signed [20:0] mag_s;
		logic signed [20:0] val;
		logic               dst;
		s.st    = st;
		s.again = 1'b0;
		s.emit  = 1'b0;
		s.res   = '0;
		s.ecode = E_NONE;
		s.fin   = 1'b0;
		dig_ok  = is_digit(b);
		acc_w   = {4'd0, st.acc} * 13'd10 + {9'd0, b[3:0]};
		acc_n   = (acc_w > {4'd0, ACC_SAT}) ? ACC_SAT : acc_w[8:0];
		mag_s   = $signed({1'b0, mag});
		val     = st.neg ? -mag_s : mag_s;
		dst     = (st.phase == PH_DST_FIRST) || (st.phase == PH_DST_BR) ||
			(st.phase == PH_DST_PLAIN);
		unique case (st.phase) inside
			PH_STD_FIRST, PH_DST_FIRST: begin
				if (b == CH_LT) begin
					s.st.phase = dst ? PH_DST_BR : PH_STD_BR;
				end else if (ends_plain(b)) begin
					s.ecode = E_EXP_ABBR;
				end else begin
					s.emit     = 1'b1;
					s.res      = make_res(dst ? K_DST_CHAR : K_STD_CHAR, b, 21'sd0, st);
					s.st.phase = dst ? PH_DST_PLAIN : PH_STD_PLAIN;
				end
			end
			PH_STD_BR, PH_DST_BR: begin
				if (b == CH_NUL) begin
					s.ecode = E_UNCLOSED;
				end else if (b == CH_GT) begin
					if (dst) begin
						s.st.phase = PH_AFTER_DST_ABBR;
					end else begin
						s.st = begin_offset(s.st, OWN_STD);
					end
				end else begin
					s.emit = 1'b1;
					s.res  = make_res(dst ? K_DST_CHAR : K_STD_CHAR, b, 21'sd0, st);
				end
			end
			PH_STD_PLAIN, PH_DST_PLAIN: begin
				if (ends_plain(b)) begin
					if (dst) begin
						s.st.phase = PH_AFTER_DST_ABBR;
					end else begin
						s.st = begin_offset(s.st, OWN_STD);
					end
					s.again = 1'b1;
				end else begin
					s.emit = 1'b1;
					s.res  = make_res(dst ? K_DST_CHAR : K_STD_CHAR, b, 21'sd0, st);
				end
			end
			PH_AFTER_STD: begin
				if (b == CH_NUL) begin
					s.emit = 1'b1;
					s.res  = make_res(K_DONE, CH_NUL, 21'sd0, st);
					s.fin  = 1'b1;
				end else begin
					s.st.phase = PH_DST_FIRST;
					s.again    = 1'b1;
				end
			end
			PH_AFTER_DST_ABBR: begin
				if (b == CH_COMMA) begin
					s.emit     = 1'b1;
					s.res      = make_res(K_DST_OFF, CH_NUL, st.std_off + SECS_HOUR, st);
					s.st.owner = OWN_START;
					s.st.phase = PH_RULE_FIRST;
				end else begin
					s.st    = begin_offset(s.st, OWN_DST);
					s.again = 1'b1;
				end
			end
			PH_OFF_SIGN: begin
				s.st = begin_int(s.st, PH_OFF_H);
				if (b == CH_MINUS) begin
					s.st.neg = 1'b1;
				end else if (b != CH_PLUS) begin
					s.again = 1'b1;
				end
			end
			PH_OFF_H: begin
				if (dig_ok) begin
					s.st.acc  = acc_n;
					s.st.seen = 1'b1;
				end else if (!st.seen) begin
					s.ecode = E_EXP_INT;
				end else if (st.acc > {1'b0, max_hours}) begin
					s.ecode = E_TOO_LARGE;
				end else begin
					s.st.hours = st.acc[7:0];
					if (b == CH_COLON) begin
						s.st = begin_int(s.st, PH_OFF_M);
					end else begin
						s       = finish_offset(s, val);
						s.again = 1'b1;
					end
				end
			end
			PH_OFF_M: begin
				if (dig_ok) begin
					s.st.acc  = acc_n;
					s.st.seen = 1'b1;
				end else if (!st.seen) begin
					s.ecode = E_EXP_INT;
				end else if (st.acc >= SIXTY) begin
					s.ecode = E_BAD_MINS;
				end else begin
					s.st.mins = st.acc[5:0];
					if (b == CH_COLON) begin
						s.st = begin_int(s.st, PH_OFF_S);
					end else begin
						s       = finish_offset(s, val);
						s.again = 1'b1;
					end
				end
			end
			PH_OFF_S: begin
				if (dig_ok) begin
					s.st.acc  = acc_n;
					s.st.seen = 1'b1;
				end else if (!st.seen) begin
					s.ecode = E_EXP_INT;
				end else if (st.acc >= SIXTY) begin
					s.ecode = E_BAD_SECS;
				end else begin
					s       = finish_offset(s, val);
					s.again = 1'b1;
				end
			end
			PH_COMMA_START: begin
				if (b == CH_COMMA) begin
					s.st.owner = OWN_START;
					s.st.phase = PH_RULE_FIRST;
				end else begin
					s.ecode = E_COMMA_START;
				end
			end
			PH_RULE_FIRST: begin
				s.st.rmon  = 4'd0;
				s.st.rweek = 3'd0;
				s.st.rday  = 9'd0;
				if (b == CH_J) begin
					s.st.rtype = RT_JULIAN;
					s.st       = begin_int(s.st, PH_RULE_J);
				end else if (b == CH_M) begin
					s.st.rtype = RT_MWD;
					s.st       = begin_int(s.st, PH_RULE_MON);
				end else begin
					s.st.rtype = RT_ORDINAL;
					s.st       = begin_int(s.st, PH_RULE_ORD);
					s.again    = 1'b1;
				end
			end
			PH_RULE_J, PH_RULE_ORD: begin
				if (dig_ok) begin
					s.st.acc  = acc_n;
					s.st.seen = 1'b1;
				end else if (!st.seen) begin
					s.ecode = E_EXP_INT;
				end else if ((st.phase == PH_RULE_J) &&
						((st.acc == 9'd0) || (st.acc > MAX_ORDINAL))) begin
					s.ecode = E_BAD_JULIAN;
				end else if ((st.phase == PH_RULE_ORD) && (st.acc > MAX_ORDINAL)) begin
					s.ecode = E_BAD_ORDINAL;
				end else begin
					s.st.rday  = st.acc;
					s.st.phase = PH_RULE_SLASH;
					s.again    = 1'b1;
				end
			end
			PH_RULE_MON: begin
				if (dig_ok) begin
					s.st.acc  = acc_n;
					s.st.seen = 1'b1;
				end else if (!st.seen) begin
					s.ecode = E_EXP_INT;
				end else if ((st.acc == 9'd0) || (st.acc > MAX_MONTH)) begin
					s.ecode = E_BAD_MONTH;
				end else if (b != CH_DOT) begin
					s.ecode = E_DOT_MONTH;
				end else begin
					s.st.rmon = st.acc[3:0];
					s.st      = begin_int(s.st, PH_RULE_WEEK);
				end
			end
			PH_RULE_WEEK: begin
				if (dig_ok) begin
					s.st.acc  = acc_n;
					s.st.seen = 1'b1;
				end else if (!st.seen) begin
					s.ecode = E_EXP_INT;
				end else if ((st.acc == 9'd0) || (st.acc > MAX_WEEK)) begin
					s.ecode = E_BAD_WEEK;
				end else if (b != CH_DOT) begin
					s.ecode = E_DOT_WEEK;
				end else begin
					s.st.rweek = st.acc[2:0];
					s.st       = begin_int(s.st, PH_RULE_WDAY);
				end
			end
			PH_RULE_WDAY: begin
				if (dig_ok) begin
					s.st.acc  = acc_n;
					s.st.seen = 1'b1;
				end else if (!st.seen) begin
					s.ecode = E_EXP_INT;
				end else if (st.acc > MAX_WDAY) begin
					s.ecode = E_BAD_WDAY;
				end else begin
					s.st.rday  = st.acc;
					s.st.phase = PH_RULE_SLASH;
					s.again    = 1'b1;
				end
			end
			PH_RULE_SLASH: begin
				if (b == CH_SLASH) begin
					s.st = begin_offset(s.st, st.owner);
				end else begin
					s       = rule_done(s, DEF_RULE_TIME);
					s.again = 1'b1;
				end
			end
			PH_COMMA_END: begin
				if (b == CH_COMMA) begin
					s.st.owner = OWN_END;
					s.st.phase = PH_RULE_FIRST;
				end else begin
					s.ecode = E_COMMA_END;
				end
			end
			PH_END: begin
				if (b == CH_NUL) begin
					s.emit = 1'b1;
					s.res  = make_res(K_DONE, CH_NUL, 21'sd0, st);
					s.fin  = 1'b1;
				end else begin
					s.ecode = E_TRAILING;
				end
			end
			default: begin
				s.st.phase = PH_STD_FIRST;
				s.again    = 1'b1;
			end
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/posix_tz_string_parser.sv
// ----------------------------------------------------------------------------
// posix_tz_string_parser
// Parses a POSIX TZ string one byte per cycle. A byte is taken into an input
// register and parsed in the following cycle, where up to four chained parse
// transitions settle and produce zero to two results; these enter an
// eight-entry result queue that the output channel drains one per cycle.
// The sustained rate is one byte per cycle as long as results are taken as
// fast as they appear; input ready drops only when the result queue cannot
// absorb two more results for the byte in the register and the next one.
// A transfer is held in the input register, then its results in the queue.
// ----------------------------------------------------------------------------
module posix_tz_string_parser #(
	parameter int unsigned MAX_HOURS  = tzp_pkg::MAX_HOURS_DEF,
	parameter int unsigned MAX_LENGTH = tzp_pkg::MAX_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         text_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         event_kind,
	output logic [7:0]         abbr_char,
	output logic signed [20:0] offset_seconds,
	output logic [1:0]         rule_type,
	output logic [3:0]         rule_month,
	output logic [2:0]         rule_week,
	output logic [8:0]         rule_day,
	output logic [4:0]         error_code,
	output logic [7:0]         error_position
);

	localparam int unsigned PW    = $clog2(MAX_LENGTH + 1);
	localparam int unsigned DEPTH = tzp_pkg::FIFO_DEPTH;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);
	localparam logic [7:0]    MaxHours = 8'(MAX_HOURS);
	localparam logic [PW-1:0] MaxPos   = PW'(MAX_LENGTH);

	logic                valid_s1;
	logic [7:0]          text_byte_s1;
	tzp_pkg::parse_st_t  st_q;
	tzp_pkg::parse_st_t  st_d;
	logic [PW-1:0]       pos_q;
	logic [PW-1:0]       pos_d;
	logic [PW-1:0]       pos_inc;
	logic [PW+7:0]       pos_ext;
	logic                in_error_q;
	logic                in_error_d;

	tzp_pkg::result_t    fifo_q [DEPTH];
	logic [AW-1:0]       wr_ptr_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [CW-1:0]       count_q;
	logic [CW:0]         load;
	logic                pop;
	logic [1:0]          n_push;

	logic [7:0]          h_src;
	logic [5:0]          m_src;
	logic [5:0]          s_src;
	logic [19:0]         mag;

	tzp_pkg::parse_st_t  cur;
	tzp_pkg::step_t      sr;
	tzp_pkg::result_t    er;
	tzp_pkg::result_t    r0;
	tzp_pkg::result_t    r1;
	logic                active;
	logic [1:0]          n_res;
	logic [4:0]          ecode;
	logic                fin;
	tzp_pkg::result_t    rd;

	assign pos_ext = {8'd0, pos_q};
	assign pos_inc = (pos_q < MaxPos) ? pos_q + PW'(1) : pos_q;

	assign h_src = (st_q.phase == tzp_pkg::PH_OFF_H) ? st_q.acc[7:0] : st_q.hours;
	assign m_src = (st_q.phase == tzp_pkg::PH_OFF_M) ? st_q.acc[5:0] : st_q.mins;
	assign s_src = (st_q.phase == tzp_pkg::PH_OFF_S) ? st_q.acc[5:0] : 6'd0;
	assign mag   = {12'd0, h_src} * 20'd3600 + {14'd0, m_src} * 20'd60 + {14'd0, s_src};

	always_comb begin
		cur    = st_q;
		active = 1'b1;
		n_res  = 2'd0;
		r0     = '0;
		r1     = '0;
		ecode  = tzp_pkg::E_NONE;
		fin    = 1'b0;
		sr     = '0;
		for (int i = 0; i < tzp_pkg::CHAIN_STEPS; i++) begin
			if (active) begin
				sr  = tzp_pkg::tz_step(cur, text_byte_s1, MaxHours, mag);
				cur = sr.st;
				if (sr.emit) begin
					if (n_res == 2'd0) begin
						r0 = sr.res;
					end else if (n_res == 2'd1) begin
						r1 = sr.res;
					end
					if (n_res != 2'd2) begin
						n_res = n_res + 2'd1;
					end
				end
				if (sr.ecode != tzp_pkg::E_NONE) begin
					ecode = sr.ecode;
				end
				fin    = fin | sr.fin;
				active = sr.again && (sr.ecode == tzp_pkg::E_NONE) && !sr.fin;
			end
		end
		er       = '0;
		er.kind  = tzp_pkg::K_ERROR;
		er.ecode = ecode;
		er.epos  = pos_ext[7:0];
		if (ecode != tzp_pkg::E_NONE) begin
			if (n_res == 2'd0) begin
				r0    = er;
				n_res = 2'd1;
			end else if (n_res == 2'd1) begin
				r1    = er;
				n_res = 2'd2;
			end
		end
	end

	assign n_push = (valid_s1 && !in_error_q) ? n_res : 2'd0;

	always_comb begin
		st_d       = st_q;
		pos_d      = pos_q;
		in_error_d = in_error_q;
		if (valid_s1) begin
			if (in_error_q || (ecode != tzp_pkg::E_NONE)) begin
				if (text_byte_s1 == tzp_pkg::CH_NUL) begin
					st_d       = tzp_pkg::ST_RESET;
					pos_d      = '0;
					in_error_d = 1'b0;
				end else begin
					if (!in_error_q) begin
						st_d = cur;
					end
					pos_d      = pos_inc;
					in_error_d = 1'b1;
				end
			end else if (fin) begin
				st_d  = tzp_pkg::ST_RESET;
				pos_d = '0;
			end else begin
				st_d  = cur;
				pos_d = pos_inc;
			end
		end
	end

	assign load     = {1'b0, count_q} + (valid_s1 ? (CW+1)'(2) : (CW+1)'(0));
	assign in_ready = (load <= (CW+1)'(DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			st_q       <= tzp_pkg::ST_RESET;
			pos_q      <= '0;
			in_error_q <= 1'b0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
		end else begin
			valid_s1   <= in_valid && in_ready;
			st_q       <= st_d;
			pos_q      <= pos_d;
			in_error_q <= in_error_d;
			wr_ptr_q   <= wr_ptr_q + AW'(n_push);
			rd_ptr_q   <= rd_ptr_q + AW'(pop);
			count_q    <= count_q + CW'(n_push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			text_byte_s1 <= text_byte;
		end
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_q + AW'(1)] <= r1;
		end
	end

	assign rd             = fifo_q[rd_ptr_q];
	assign event_kind     = rd.kind;
	assign abbr_char      = rd.ch;
	assign offset_seconds = rd.off;
	assign rule_type      = rd.rtype;
	assign rule_month     = rd.rmon;
	assign rule_week      = rd.rweek;
	assign rule_day       = rd.rday;
	assign error_code     = rd.ecode;
	assign error_position = rd.epos;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Result queue count exceeds its depth.");

	a_quiet_in_error: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && in_error_q) |-> (n_push == 2'd0))
		else $error("A result was queued while skipping bytes after an error.");

	a_restart_on_nul: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (text_byte_s1 == tzp_pkg::CH_NUL)) |=>
		((st_q.phase == tzp_pkg::PH_STD_FIRST) && (pos_q == '0) && !in_error_q))
		else $error("Parser did not restart after the terminating byte.");

endmodule
